@@ hdl/data_processing_alu_shifter_macros.svh @@
// Assertion macros shared by the data-processing ALU/shifter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef DATA_PROCESSING_ALU_SHIFTER_MACROS_SVH
`define DATA_PROCESSING_ALU_SHIFTER_MACROS_SVH

// same-cycle implication
`define DPAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpas: same-cycle check failed");

// next-cycle implication
`define DPAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpas: next-cycle check failed");

`endif

@@ hdl/dpas_pkg.sv @@
// Types, codes and field positions for the data-processing ALU/shifter.
// No dependencies; used by every module of the block.
`default_nettype none

package dpas_pkg;

    typedef enum logic [3:0] {
        OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC,
        OP_TST, OP_TEQ, OP_CMP, OP_CMN, OP_ORR, OP_MOV, OP_BIC, OP_MVN
    } op_t;

    typedef enum logic [3:0] {
        COND_EQ, COND_NE, COND_CS, COND_CC, COND_MI, COND_PL, COND_VS, COND_VC,
        COND_HI, COND_LS, COND_GE, COND_LT, COND_GT, COND_LE, COND_AL, COND_NV
    } cond_t;

    typedef enum logic [1:0] {
        SH_LSL, SH_LSR, SH_ASR, SH_ROR
    } shift_t;

    // instruction word bit positions
    localparam int IMM_FORM_BIT = 25;
    localparam int SAVE_BIT     = 20;
    localparam int REG_AMT_BIT  = 4;

    // flags nibble positions
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    localparam logic [7:0] SHIFT_FULL = 8'd32;

    // decode -> shifter
    typedef struct packed {
        logic        pass;
        op_t         op;
        logic        save;
        logic [3:0]  dest;
        logic [31:0] rn;
        logic [3:0]  flags;
        logic [31:0] sh_val;
        shift_t      sh_type;
        logic [7:0]  sh_amt;
        logic        rrx;
    } dec_t;

    // shifter -> ALU
    typedef struct packed {
        logic        pass;
        op_t         op;
        logic        save;
        logic [3:0]  dest;
        logic [31:0] rn;
        logic [3:0]  flags;
        logic [31:0] op2;
        logic        sc;
    } shf_t;

    // ALU result beat
    typedef struct packed {
        logic        pass;
        logic [3:0]  flags;
        logic        wr;
        logic [3:0]  dest;
        logic [31:0] result;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/dpas_decode.sv @@
// Stage 1: condition check and operand-2 shift setup.
// Depends on dpas_pkg.
`default_nettype none

module dpas_decode (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   iw,
    input  wire logic [31:0]   rn,
    input  wire logic [31:0]   rm,
    input  wire logic [7:0]    amt,
    input  wire logic [3:0]    flags,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dpas_pkg::dec_t     out_data
);

    logic           valid_reg;
    dpas_pkg::dec_t dec_reg;
    dpas_pkg::dec_t dec_next;
    logic           pass;
    logic           n_f, z_f, c_f, v_f;
    logic [4:0]     imm_n;
    dpas_pkg::shift_t imm_type;

    assign n_f = flags[dpas_pkg::FLAG_N];
    assign z_f = flags[dpas_pkg::FLAG_Z];
    assign c_f = flags[dpas_pkg::FLAG_C];
    assign v_f = flags[dpas_pkg::FLAG_V];
    assign imm_n    = iw[11:7];
    assign imm_type = dpas_pkg::shift_t'(iw[6:5]);

    always_comb
    begin
        pass = 1'b0;
        unique case (dpas_pkg::cond_t'(iw[31:28]))
            dpas_pkg::COND_EQ: pass = z_f;
            dpas_pkg::COND_NE: pass = !z_f;
            dpas_pkg::COND_CS: pass = c_f;
            dpas_pkg::COND_CC: pass = !c_f;
            dpas_pkg::COND_MI: pass = n_f;
            dpas_pkg::COND_PL: pass = !n_f;
            dpas_pkg::COND_VS: pass = v_f;
            dpas_pkg::COND_VC: pass = !v_f;
            dpas_pkg::COND_HI: pass = c_f && !z_f;
            dpas_pkg::COND_LS: pass = !c_f || z_f;
            dpas_pkg::COND_GE: pass = n_f == v_f;
            dpas_pkg::COND_LT: pass = n_f != v_f;
            dpas_pkg::COND_GT: pass = !z_f && (n_f == v_f);
            dpas_pkg::COND_LE: pass = z_f || (n_f != v_f);
            dpas_pkg::COND_AL: pass = 1'b1;
            dpas_pkg::COND_NV: pass = 1'b0;
        endcase
    end

    always_comb
    begin
        dec_next.pass  = pass;
        dec_next.op    = dpas_pkg::op_t'(iw[24:21]);
        dec_next.save  = iw[dpas_pkg::SAVE_BIT];
        dec_next.dest  = iw[15:12];
        dec_next.rn    = rn;
        dec_next.flags = flags;
        dec_next.rrx   = 1'b0;
        if (iw[dpas_pkg::IMM_FORM_BIT])
        begin
            // rotated immediate behaves as a register ROR by an amount under 32
            dec_next.sh_val  = {24'd0, iw[7:0]};
            dec_next.sh_type = dpas_pkg::SH_ROR;
            dec_next.sh_amt  = {3'd0, iw[11:8], 1'b0};
        end
        else if (iw[dpas_pkg::REG_AMT_BIT])
        begin
            dec_next.sh_val  = rm;
            dec_next.sh_type = dpas_pkg::shift_t'(iw[6:5]);
            dec_next.sh_amt  = amt;
        end
        else
        begin
            dec_next.sh_val  = rm;
            dec_next.sh_type = imm_type;
            if (imm_type == dpas_pkg::SH_ROR && imm_n == 5'd0)
            begin
                dec_next.rrx    = 1'b1;
                dec_next.sh_amt = 8'd0;
            end
            else if (imm_type == dpas_pkg::SH_LSL || imm_n != 5'd0)
            begin
                dec_next.sh_amt = {3'd0, imm_n};
            end
            else
            begin
                // LSR/ASR #0 encodes a full-width shift
                dec_next.sh_amt = dpas_pkg::SHIFT_FULL;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = dec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            dec_reg <= dec_next;
    end

endmodule

`default_nettype wire

@@ hdl/dpas_shift.sv @@
// Stage 2: barrel shifter producing operand 2 and the shifter carry.
// Depends on dpas_pkg.
`default_nettype none

module dpas_shift (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dpas_pkg::dec_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dpas_pkg::shf_t     out_data
);

    logic           valid_reg;
    dpas_pkg::shf_t shf_reg;
    dpas_pkg::shf_t shf_next;
    logic [31:0]    v;
    logic [7:0]     amt;
    logic           c_in;
    logic [32:0]    lsl_w;
    logic [32:0]    lsr_w;
    logic signed [32:0] asr_w;
    logic [5:0]     asr_amt;
    logic [63:0]    ror_w;
    logic [31:0]    op2;
    logic           sc;

    assign v    = in_data.sh_val;
    assign amt  = in_data.sh_amt;
    assign c_in = in_data.flags[dpas_pkg::FLAG_C];

    // for LSL, LSR and ASR the carry falls out as the extra bit beyond the word
    assign lsl_w   = {1'b0, v} << amt;
    assign lsr_w   = {v, 1'b0} >> amt;
    assign asr_amt = (amt > dpas_pkg::SHIFT_FULL) ? 6'd32 : amt[5:0];
    assign asr_w   = $signed({v, 1'b0}) >>> asr_amt;
    assign ror_w   = {v, v} >> amt[4:0];

    always_comb
    begin
        op2 = v;
        sc  = c_in;
        if (in_data.rrx)
        begin
            op2 = {c_in, v[31:1]};
            sc  = v[0];
        end
        else if (amt != 8'd0)
        begin
            case (in_data.sh_type)
                dpas_pkg::SH_LSL:
                begin
                    op2 = lsl_w[31:0];
                    sc  = lsl_w[32];
                end
                dpas_pkg::SH_LSR:
                begin
                    op2 = lsr_w[32:1];
                    sc  = lsr_w[0];
                end
                dpas_pkg::SH_ASR:
                begin
                    op2 = asr_w[32:1];
                    sc  = asr_w[0];
                end
                default:
                begin
                    op2 = ror_w[31:0];
                    sc  = ror_w[31];
                end
            endcase
        end
    end

    always_comb
    begin
        shf_next.pass  = in_data.pass;
        shf_next.op    = in_data.op;
        shf_next.save  = in_data.save;
        shf_next.dest  = in_data.dest;
        shf_next.rn    = in_data.rn;
        shf_next.flags = in_data.flags;
        shf_next.op2   = op2;
        shf_next.sc    = sc;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = shf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            shf_reg <= shf_next;
    end

endmodule

`default_nettype wire

@@ hdl/dpas_alu.sv @@
// Stage 3: 16-operation ALU, flag update and output register.
// Depends on dpas_pkg.
`default_nettype none

module dpas_alu (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dpas_pkg::shf_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dpas_pkg::res_t     out_data
);

    logic           valid_reg;
    dpas_pkg::res_t res_reg;
    dpas_pkg::res_t res_next;
    logic [31:0]    rn;
    logic [31:0]    op2;
    logic           c_in;
    logic [31:0]    add_a;
    logic [31:0]    add_b;
    logic           add_c;
    logic [32:0]    sum;
    logic           add_v;
    logic           arith;
    logic [31:0]    res;

    assign rn   = in_data.rn;
    assign op2  = in_data.op2;
    assign c_in = in_data.flags[dpas_pkg::FLAG_C];

    always_comb
    begin
        add_a = rn;
        add_b = op2;
        add_c = 1'b0;
        case (in_data.op)
            dpas_pkg::OP_SUB, dpas_pkg::OP_CMP:
            begin
                add_b = ~op2;
                add_c = 1'b1;
            end
            dpas_pkg::OP_RSB:
            begin
                add_a = op2;
                add_b = ~rn;
                add_c = 1'b1;
            end
            dpas_pkg::OP_ADC:
                add_c = c_in;
            dpas_pkg::OP_SBC:
            begin
                add_b = ~op2;
                add_c = c_in;
            end
            dpas_pkg::OP_RSC:
            begin
                add_a = op2;
                add_b = ~rn;
                add_c = c_in;
            end
            default:
            begin
                add_a = rn;
                add_b = op2;
                add_c = 1'b0;
            end
        endcase
    end

    assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_c};
    assign add_v = (~(add_a[31] ^ add_b[31])) & (add_a[31] ^ sum[31]);

    always_comb
    begin
        arith = 1'b0;
        case (in_data.op)
            dpas_pkg::OP_AND, dpas_pkg::OP_TST: res = rn & op2;
            dpas_pkg::OP_EOR, dpas_pkg::OP_TEQ: res = rn ^ op2;
            dpas_pkg::OP_ORR:                   res = rn | op2;
            dpas_pkg::OP_MOV:                   res = op2;
            dpas_pkg::OP_BIC:                   res = rn & ~op2;
            dpas_pkg::OP_MVN:                   res = ~op2;
            default:
            begin
                res   = sum[31:0];
                arith = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        res_next.pass   = in_data.pass;
        res_next.dest   = in_data.dest;
        res_next.flags  = in_data.flags;
        res_next.wr     = 1'b0;
        res_next.result = 32'd0;
        if (in_data.pass)
        begin
            res_next.result = res;
            res_next.wr = !(in_data.op == dpas_pkg::OP_TST || in_data.op == dpas_pkg::OP_TEQ
                         || in_data.op == dpas_pkg::OP_CMP || in_data.op == dpas_pkg::OP_CMN);
            if (in_data.save)
            begin
                res_next.flags[dpas_pkg::FLAG_N] = res[31];
                res_next.flags[dpas_pkg::FLAG_Z] = (res == 32'd0);
                if (arith)
                begin
                    res_next.flags[dpas_pkg::FLAG_C] = sum[32];
                    res_next.flags[dpas_pkg::FLAG_V] = add_v;
                end
                else
                begin
                    // logical ops keep V
                    res_next.flags[dpas_pkg::FLAG_C] = in_data.sc;
                end
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            res_reg <= res_next;
    end

endmodule

`default_nettype wire

@@ hdl/data_processing_alu_shifter.sv @@
// Data-processing execute unit: condition check, barrel shifter, ALU, flags.
// Pipeline: the decode, shifter and ALU registers lie between an accepted input beat and m_tvalid.
// Throughput: one beat per cycle; each stage advances when it is empty or the next one takes.
// Reset: rst_n clears the three stage valid bits asynchronously; payload is not reset.
// Depends on dpas_pkg, dpas_decode, dpas_shift, dpas_alu and the macros header.
`default_nettype none
`include "data_processing_alu_shifter_macros.svh"

module data_processing_alu_shifter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    // [31:0] instruction_word, [63:32] base_value, [95:64] shifted_value,
    // [103:96] amount_value, [107:104] flags_in, [111:108] zero
    input  wire logic [111:0]   s_tdata,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // [31:0] result_value, [35:32] dest_index, [36] write_result,
    // [40:37] flags_out, [41] condition_passed, [47:42] zero
    output logic [47:0]         m_tdata
);

    logic           dec_valid;
    logic           dec_ready;
    dpas_pkg::dec_t dec_data;
    logic           shf_valid;
    logic           shf_ready;
    dpas_pkg::shf_t shf_data;
    dpas_pkg::res_t res_data;

    dpas_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .iw        (s_tdata[31:0]),
        .rn        (s_tdata[63:32]),
        .rm        (s_tdata[95:64]),
        .amt       (s_tdata[103:96]),
        .flags     (s_tdata[107:104]),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    dpas_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (shf_valid),
        .out_ready (shf_ready),
        .out_data  (shf_data)
    );

    dpas_alu u_alu (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (shf_valid),
        .in_ready  (shf_ready),
        .in_data   (shf_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata = {6'd0, res_data.pass, res_data.flags, res_data.wr,
                      res_data.dest, res_data.result};

    // an accepted beat always lands in the decode register
    `DPAS_ASSERT_NXT(a_accept_lands, clk, rst_n, s_tvalid && s_tready, dec_valid)
    // a beat stalled between shifter and ALU stays put
    `DPAS_ASSERT_NXT(a_shf_holds, clk, rst_n, shf_valid && !shf_ready, shf_valid)
    // an empty output stage lets the whole pipe take a new beat
    `DPAS_ASSERT_IMP(a_empty_ready, clk, rst_n, !m_tvalid, s_tready)

endmodule

`default_nettype wire

@@ tb/tb_data_processing_alu_shifter.sv @@
// Self-checking bench for the data-processing ALU/shifter: directed corner cases, then
// random instruction beats under source gaps, sink stalls and a long sink hold-off.
// Depends on dpas_pkg and the data_processing_alu_shifter RTL.
`timescale 1ns / 100ps

module tb_data_processing_alu_shifter;

    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] word;
        logic [31:0] base;
        logic [31:0] shifted;
        logic [7:0]  amount;
        logic [3:0]  flags;
    } beat_t;

    typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH, PH_HOLD} phase_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;

    beat_t        on_bus = '0;
    beat_t        pending[$];
    logic [47:0]  results_due[$];
    phase_t       phase = PH_FREE;
    int           hold_count = 0;
    logic         holding_off;
    int           beats_sent = 0;
    int           beats_checked = 0;
    int           passed_count = 0;
    int           mismatch_count = 0;

    // flags, amount, shifted, base, word from the top down; upper nibble is zero
    assign s_tdata = {4'd0, on_bus.flags, on_bus.amount, on_bus.shifted, on_bus.base,
                      on_bus.word};

    data_processing_alu_shifter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] rotate_right(logic [31:0] v, logic [4:0] k);
        return (v >> k) | (v << (6'd32 - k));
    endfunction

    // register-shift semantics for amounts 0..255
    function automatic logic [31:0] shift_value(dpas_pkg::shift_t kind, logic [31:0] v,
                                                logic [7:0] n, logic c_in,
                                                output logic c_out);
        logic [63:0]        wide;
        logic signed [63:0] swide;
        logic [31:0]        rot;
        c_out = c_in;
        if (n == 8'd0)
            return v;
        case (kind)
            dpas_pkg::SH_LSL:
            begin
                wide = {32'd0, v} << n;
                c_out = wide[32];
                return wide[31:0];
            end
            dpas_pkg::SH_LSR:
            begin
                wide = {v, 32'd0} >> n;
                c_out = wide[31];
                return wide[63:32];
            end
            dpas_pkg::SH_ASR:
            begin
                swide = $signed({v, 32'd0});
                swide = swide >>> n;
                c_out = swide[31];
                return swide[63:32];
            end
            default:
            begin
                // amount mod 32, zero acting as 32: carry is always bit 31 of the result
                rot = rotate_right(v, n[4:0]);
                c_out = rot[31];
                return rot;
            end
        endcase
    endfunction

    function automatic logic [47:0] predict_execute(beat_t b);
        dpas_pkg::cond_t  cnd;
        dpas_pkg::op_t    opc;
        dpas_pkg::shift_t kind;
        logic        fn, fz, fc, fv;
        logic        pass, sc, logical, wr, ecin;
        logic [4:0]  rot, n5;
        logic [31:0] op2, res, ea, eb;
        logic [32:0] sum;
        logic [3:0]  fout;
        cnd  = dpas_pkg::cond_t'(b.word[31:28]);
        opc  = dpas_pkg::op_t'(b.word[24:21]);
        kind = dpas_pkg::shift_t'(b.word[6:5]);
        {fn, fz, fc, fv} = b.flags;
        case (cnd)
            dpas_pkg::COND_EQ: pass = fz;
            dpas_pkg::COND_NE: pass = !fz;
            dpas_pkg::COND_CS: pass = fc;
            dpas_pkg::COND_CC: pass = !fc;
            dpas_pkg::COND_MI: pass = fn;
            dpas_pkg::COND_PL: pass = !fn;
            dpas_pkg::COND_VS: pass = fv;
            dpas_pkg::COND_VC: pass = !fv;
            dpas_pkg::COND_HI: pass = fc && !fz;
            dpas_pkg::COND_LS: pass = !fc || fz;
            dpas_pkg::COND_GE: pass = (fn == fv);
            dpas_pkg::COND_LT: pass = (fn != fv);
            dpas_pkg::COND_GT: pass = !fz && (fn == fv);
            dpas_pkg::COND_LE: pass = fz || (fn != fv);
            dpas_pkg::COND_AL: pass = 1'b1;
            default:           pass = 1'b0;
        endcase

        sc = fc;
        if (b.word[dpas_pkg::IMM_FORM_BIT])
        begin
            rot = {b.word[11:8], 1'b0};
            op2 = rotate_right({24'd0, b.word[7:0]}, rot);
            if (rot != 5'd0)
                sc = op2[31];
        end
        else if (b.word[dpas_pkg::REG_AMT_BIT])
            op2 = shift_value(kind, b.shifted, b.amount, fc, sc);
        else
        begin
            n5 = b.word[11:7];
            if (kind == dpas_pkg::SH_ROR && n5 == 5'd0)
            begin
                // RRX
                op2 = {fc, b.shifted[31:1]};
                sc = b.shifted[0];
            end
            else if (kind == dpas_pkg::SH_LSL || n5 != 5'd0)
                op2 = shift_value(kind, b.shifted, {3'd0, n5}, fc, sc);
            else
                op2 = shift_value(kind, b.shifted, dpas_pkg::SHIFT_FULL, fc, sc);
        end

        res = 32'd0;
        wr = 1'b0;
        fout = b.flags;
        if (pass)
        begin
            logical = 1'b1;
            ea = 32'd0;
            eb = 32'd0;
            ecin = 1'b0;
            sum = 33'd0;
            case (opc)
                dpas_pkg::OP_AND, dpas_pkg::OP_TST: res = b.base & op2;
                dpas_pkg::OP_EOR, dpas_pkg::OP_TEQ: res = b.base ^ op2;
                dpas_pkg::OP_ORR:                   res = b.base | op2;
                dpas_pkg::OP_MOV:                   res = op2;
                dpas_pkg::OP_BIC:                   res = b.base & ~op2;
                dpas_pkg::OP_MVN:                   res = ~op2;
                default:
                begin
                    logical = 1'b0;
                    case (opc)
                        dpas_pkg::OP_SUB, dpas_pkg::OP_CMP:
                            {ea, eb, ecin} = {b.base, ~op2, 1'b1};
                        dpas_pkg::OP_RSB:
                            {ea, eb, ecin} = {op2, ~b.base, 1'b1};
                        dpas_pkg::OP_ADD, dpas_pkg::OP_CMN:
                            {ea, eb, ecin} = {b.base, op2, 1'b0};
                        dpas_pkg::OP_ADC:
                            {ea, eb, ecin} = {b.base, op2, fc};
                        dpas_pkg::OP_SBC:
                            {ea, eb, ecin} = {b.base, ~op2, fc};
                        default:
                            {ea, eb, ecin} = {op2, ~b.base, fc};
                    endcase
                    sum = {1'b0, ea} + {1'b0, eb} + {32'd0, ecin};
                    res = sum[31:0];
                end
            endcase
            if (b.word[dpas_pkg::SAVE_BIT])
            begin
                fout[dpas_pkg::FLAG_N] = res[31];
                fout[dpas_pkg::FLAG_Z] = (res == 32'd0);
                if (logical)
                    fout[dpas_pkg::FLAG_C] = sc;
                else
                begin
                    fout[dpas_pkg::FLAG_C] = sum[32];
                    fout[dpas_pkg::FLAG_V] = ~(ea[31] ^ eb[31]) & (ea[31] ^ res[31]);
                end
            end
            wr = (opc != dpas_pkg::OP_TST && opc != dpas_pkg::OP_TEQ
                  && opc != dpas_pkg::OP_CMP && opc != dpas_pkg::OP_CMN);
        end
        return {6'd0, pass, fout, wr, b.word[15:12], res};
    endfunction

    function automatic logic [31:0] make_word(dpas_pkg::cond_t c, dpas_pkg::op_t o, logic s,
                                              logic [3:0] rd, logic imm, logic [11:0] low);
        return {c, 2'b00, imm, o, s, 4'h3, rd, low};
    endfunction

    // operand-2 field: register shift by rs, or shift by immediate
    function automatic logic [11:0] reg_shift(dpas_pkg::shift_t t);
        return {4'h2, 1'b0, t, 1'b1, 4'h4};
    endfunction

    function automatic logic [11:0] imm_shift(logic [4:0] n, dpas_pkg::shift_t t);
        return {n, t, 1'b0, 4'h4};
    endfunction

    function automatic beat_t mk_beat(logic [31:0] word, logic [31:0] base,
                                      logic [31:0] shifted, logic [7:0] amount,
                                      logic [3:0] flags);
        beat_t b;
        b.word = word;
        b.base = base;
        b.shifted = shifted;
        b.amount = amount;
        b.flags = flags;
        return b;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] pick_amount();
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1:       return 8'd32;
            2:       return 8'($urandom_range(1, 31));
            3:       return 8'($urandom_range(33, 255));
            4:       return 8'($urandom_range(1, 7) * 32);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        b.word = $urandom();
        case ($urandom_range(0, 2))
            0:
            begin
                b.word[dpas_pkg::IMM_FORM_BIT] = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    b.word[11:8] = 4'd0;
            end
            1:
            begin
                b.word[dpas_pkg::IMM_FORM_BIT] = 1'b0;
                b.word[dpas_pkg::REG_AMT_BIT] = 1'b0;
                if ($urandom_range(0, 3) == 0)
                    b.word[11:7] = 5'd0;
            end
            default:
            begin
                b.word[dpas_pkg::IMM_FORM_BIT] = 1'b0;
                b.word[dpas_pkg::REG_AMT_BIT] = 1'b1;
            end
        endcase
        // lean toward always-execute so more beats pass their condition
        if ($urandom_range(0, 3) == 0)
            b.word[31:28] = dpas_pkg::COND_AL;
        b.base = pick_word();
        b.shifted = ($urandom_range(0, 7) == 0) ? b.base : pick_word();
        b.amount = pick_amount();
        b.flags = 4'($urandom_range(0, 15));
        return b;
    endfunction

    function automatic int idle_pct(phase_t ph, logic sink);
        case (ph)
            PH_SRC_IDLE:   return sink ? 0 : 51;
            PH_SINK_STALL: return sink ? 51 : 0;
            PH_BOTH:       return 36;
            default:       return 0;
        endcase
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    task automatic feed_random(input phase_t ph, input int count);
        phase = ph;
        repeat (count)
            pending.push_back(random_beat());
        while (pending.size() != 0)
            @(negedge clk);
    endtask

    // source side: predict at acceptance, then offer the next pending beat
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                results_due.push_back(predict_execute(on_bus));
                beats_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending.size() != 0 && $urandom_range(0, 99) >= idle_pct(phase, 1'b0))
                begin
                    on_bus <= pending.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            hold_count <= 0;
        else if (phase == PH_HOLD && hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    assign holding_off = (phase == PH_HOLD) && (hold_count < HOLD_CYCLES);

    // sink side
    always @(posedge clk)
    begin
        logic [47:0] want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= !holding_off && ($urandom_range(0, 99) >= idle_pct(phase, 1'b1));
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t ns: unexpected result beat, expected none, got %h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("result_value", want[31:0], m_tdata[31:0]);
                    check_field("dest_index", {28'd0, want[35:32]}, {28'd0, m_tdata[35:32]});
                    check_field("write_result", {31'd0, want[36]}, {31'd0, m_tdata[36]});
                    check_field("flags_out", {28'd0, want[40:37]}, {28'd0, m_tdata[40:37]});
                    check_field("condition_passed", {31'd0, want[41]}, {31'd0, m_tdata[41]});
                    if (want[41])
                        passed_count++;
                end
                beats_checked++;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every opcode with S set, register shifted by immediate zero
        for (int k = 0; k < 16; k++)
            pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::op_t'(k), 1'b1,
                                                4'd1, 1'b0,
                                                imm_shift(5'd0, dpas_pkg::SH_LSL)),
                                      pick_word(), pick_word(), pick_amount(),
                                      4'($urandom_range(0, 15))));
        // never condition
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_NV, dpas_pkg::OP_MOV, 1'b1, 4'd2,
                                            1'b1, 12'h0ff),
                                  32'h1234_5678, 32'h1, 8'd0, 4'hf));
        // register shifts at and beyond 32
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_MOV, 1'b1, 4'd3,
                                            1'b0, reg_shift(dpas_pkg::SH_LSL)),
                                  32'h0, 32'h1, 8'd32, 4'h0));
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_MOV, 1'b1, 4'd4,
                                            1'b0, reg_shift(dpas_pkg::SH_LSR)),
                                  32'h0, 32'h8000_0000, 8'd32, 4'h0));
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_MOV, 1'b1, 4'd5,
                                            1'b0, reg_shift(dpas_pkg::SH_LSL)),
                                  32'h0, 32'hffff_ffff, 8'd33, 4'h2));
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_ORR, 1'b1, 4'd6,
                                            1'b0, reg_shift(dpas_pkg::SH_ASR)),
                                  32'h0, 32'h8000_0001, 8'd200, 4'h0));
        // rotate by a multiple of 32, with bits 27:26 and bit 7 set (both ignored)
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_MOV, 1'b1, 4'd7,
                                            1'b0, reg_shift(dpas_pkg::SH_ROR))
                                  | 32'h0c00_0080,
                                  32'h0, 32'h8000_0002, 8'd64, 4'h0));
        // register amount zero keeps carry
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_MOV, 1'b1, 4'd8,
                                            1'b0, reg_shift(dpas_pkg::SH_LSR)),
                                  32'h0, 32'hffff_fffe, 8'd0, 4'h2));
        // immediate LSR/ASR by zero mean 32
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_MOV, 1'b1, 4'd9,
                                            1'b0, imm_shift(5'd0, dpas_pkg::SH_LSR)),
                                  32'h0, 32'h8000_0000, 8'd0, 4'h0));
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_MOV, 1'b1, 4'd10,
                                            1'b0, imm_shift(5'd0, dpas_pkg::SH_ASR)),
                                  32'h0, 32'h8000_0000, 8'd0, 4'h0));
        // RRX into destination 15 with S
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_ADD, 1'b1, 4'd15,
                                            1'b0, imm_shift(5'd0, dpas_pkg::SH_ROR)),
                                  32'h1, 32'h1, 8'd0, 4'h2));
        // rotated immediate: zero rotate keeps C, nonzero takes bit 31
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_MOV, 1'b1, 4'd11,
                                            1'b1, 12'h0ff),
                                  32'h0, 32'h0, 8'd0, 4'h2));
        pending.push_back(mk_beat(make_word(dpas_pkg::COND_AL, dpas_pkg::OP_MOV, 1'b1, 4'd12,
                                            1'b1, 12'h4ff),
                                  32'h0, 32'h0, 8'd0, 4'h0));
        while (pending.size() != 0)
            @(negedge clk);

        feed_random(PH_FREE, 400);
        feed_random(PH_SRC_IDLE, 400);
        feed_random(PH_SINK_STALL, 400);
        feed_random(PH_BOTH, 400);
        feed_random(PH_HOLD, 100);

        phase = PH_FREE;
        while (pending.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Ran %0d instruction beats (%0d met their condition), %0d results checked,",
                 beats_sent, passed_count, beats_checked);
        $display("through free flow, source gaps, sink stalls, both, and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
